// ===== sv/vcsq_pkg.sv =====
// Shared types and constants for the voltage class stability qualifier.
// No dependencies; used by vcsq_ring and the top level.
package vcsq_pkg;

    localparam int TIME_W  = 32;
    localparam int CLASS_W = 3;
    localparam int CFG_W   = 16;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [CFG_W-1:0]   cfg_word_t;
    typedef logic               cfg_idx_t;

    // class codes
    localparam class_t CLASS_PROBE_TRIGGERED = 3'd0;
    localparam class_t CLASS_NONE            = 3'd6;

    // register indexes
    localparam cfg_idx_t REG_STABILITY_THRESHOLD = 1'b0;
    localparam cfg_idx_t REG_TRIGGER_DELAY       = 1'b1;

    // register reset values
    localparam cfg_word_t THRESHOLD_RESET     = 16'd200;
    localparam cfg_word_t TRIGGER_DELAY_RESET = 16'd200;

endpackage

// ===== sv/vcsq_ring.sv =====
// Timestamp ring for the stability qualifier: write pointer, storage, and a
// registered look-ahead read of the oldest slot. Depends on vcsq_pkg.
module vcsq_ring #(
    parameter int DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vcsq_pkg::time_t push_time,
    output vcsq_pkg::time_t oldest_time
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    vcsq_pkg::time_t ring_mem [DEPTH];
    vcsq_pkg::time_t oldest_reg;
    logic [IW-1:0]   head_reg;
    logic [IW-1:0]   head_next;
    logic [IW-1:0]   ahead_idx;

    // slot after the next write slot: oldest entry once the ring is full
    always_comb
    begin
        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        ahead_idx = (head_next == LAST_IDX) ? '0 : head_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (push)
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[head_reg] <= push_time;
        end
    end

    // fetch ahead; forward the word being written when a one- or two-deep ring wraps onto it
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (ahead_idx == head_reg)
            begin
                oldest_reg <= push_time;
            end
            else
            begin
                oldest_reg <= ring_mem[ahead_idx];
            end
        end
    end

    assign oldest_time = oldest_reg;

endmodule

// ===== sv/voltage_class_stability_qualifier_unit.sv =====
// Top level of the voltage class stability qualifier.
// Depends on vcsq_pkg and vcsq_ring.
//
// Debounces a stream of timestamped tool-detection class words. Each input
// word yields one result word. A word whose timestamp equals the last taken
// one is dropped (accepted = 0, state unchanged). Otherwise the timestamp is
// stored in a ring of LOG_DEPTH entries and the run of equal classes is
// tracked; run_period_ms is the newest time minus the time of the oldest
// sample of the run still in the ring, modulo 2^32. is_stable rises once the
// period reaches stability_threshold_ms; report_pulse fires once per run when
// the period also reaches trigger_report_delay_ms (probe-triggered class) or
// at once (any other class). Throughput is one word per clock while out_ready
// holds; a word moves from the input register into the output register through
// the single compare/subtract pass between them.
// The ring needs no clearing after reset. Write configuration only while idle.
module voltage_class_stability_qualifier_unit #(
    parameter int LOG_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  vcsq_pkg::cfg_idx_t    cfg_index,
    input  vcsq_pkg::cfg_word_t   cfg_wdata,
    // input words
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vcsq_pkg::time_t       time_ms,
    input  vcsq_pkg::class_t      voltage_class,
    // result words
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic                  is_stable,
    output vcsq_pkg::class_t      current_class,
    output logic                  report_pulse,
    output vcsq_pkg::time_t       run_period_ms
);

    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam logic [CW-1:0] RUN_MAX = CW'(LOG_DEPTH);
    localparam logic [CW-1:0] RUN_ONE = CW'(1);

    // configuration registers
    vcsq_pkg::cfg_word_t thr_reg;
    vcsq_pkg::cfg_word_t delay_reg;

    // input register
    logic              s1_valid_reg;
    vcsq_pkg::time_t   s1_time_reg;
    vcsq_pkg::class_t  s1_class_reg;

    // qualifier state
    logic              any_reg;
    vcsq_pkg::time_t   last_time_reg;
    vcsq_pkg::class_t  last_class_reg;
    logic [CW-1:0]     run_len_reg;
    vcsq_pkg::time_t   run_start_reg;
    logic              stable_reg;
    logic              reported_reg;

    // output register
    logic              out_valid_reg;
    logic              acc_reg;
    logic              stab_out_reg;
    vcsq_pkg::class_t  class_out_reg;
    logic              pulse_reg;
    vcsq_pkg::time_t   period_reg;

    // datapath
    logic              advance;
    logic              take;
    logic              dup;
    logic              push;
    logic              change;
    logic [CW-1:0]     run_next;
    vcsq_pkg::time_t   ring_oldest;
    vcsq_pkg::time_t   oldest;
    vcsq_pkg::time_t   period;
    vcsq_pkg::time_t   delay;
    logic              stable_old;
    logic              reported_old;
    logic              stable_next;
    logic              reported_next;
    logic              pulse;

    // output stage frees whenever it is empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        dup    = any_reg && (last_time_reg == s1_time_reg);
        push   = s1_valid_reg && advance && !dup;
        change = s1_class_reg != last_class_reg;

        if (change)
        begin
            run_next = RUN_ONE;
        end
        else if (run_len_reg == RUN_MAX)
        begin
            run_next = run_len_reg;
        end
        else
        begin
            run_next = run_len_reg + 1'b1;
        end

        // oldest run sample: this word, the run start, or the ring's tail once full
        if (run_next == RUN_ONE)
        begin
            oldest = s1_time_reg;
        end
        else if (run_next == RUN_MAX)
        begin
            oldest = ring_oldest;
        end
        else
        begin
            oldest = run_start_reg;
        end
        period = s1_time_reg - oldest;

        stable_old   = change ? 1'b0 : stable_reg;
        reported_old = change ? 1'b0 : reported_reg;
        delay = (s1_class_reg == vcsq_pkg::CLASS_PROBE_TRIGGERED)
              ? {16'b0, delay_reg} : '0;

        if (!reported_old)
        begin
            stable_next   = stable_old || (period >= {16'b0, thr_reg});
            pulse         = stable_next && (period >= delay);
            reported_next = pulse;
        end
        else
        begin
            stable_next   = stable_old;
            pulse         = 1'b0;
            reported_next = reported_old;
        end
    end

    vcsq_ring #(
        .DEPTH (LOG_DEPTH)
    ) u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_time   (s1_time_reg),
        .oldest_time (ring_oldest)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= vcsq_pkg::THRESHOLD_RESET;
            delay_reg <= vcsq_pkg::TRIGGER_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vcsq_pkg::REG_STABILITY_THRESHOLD: thr_reg   <= cfg_wdata;
                vcsq_pkg::REG_TRIGGER_DELAY:       delay_reg <= cfg_wdata;
                default:                           thr_reg   <= thr_reg;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // hold payload until a new word is taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_time_reg  <= time_ms;
            s1_class_reg <= voltage_class;
        end
    end

    // advance the qualifier state on every stored word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg        <= 1'b0;
            last_class_reg <= vcsq_pkg::CLASS_NONE;
            run_len_reg    <= '0;
            stable_reg     <= 1'b0;
            reported_reg   <= 1'b0;
        end
        else if (push)
        begin
            any_reg        <= 1'b1;
            last_class_reg <= s1_class_reg;
            run_len_reg    <= run_next;
            stable_reg     <= stable_next;
            reported_reg   <= reported_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            last_time_reg <= s1_time_reg;
            if (run_next == RUN_ONE)
            begin
                run_start_reg <= s1_time_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            if (dup)
            begin
                acc_reg       <= 1'b0;
                stab_out_reg  <= stable_reg;
                class_out_reg <= last_class_reg;
                pulse_reg     <= 1'b0;
                period_reg    <= '0;
            end
            else
            begin
                acc_reg       <= 1'b1;
                stab_out_reg  <= stable_next;
                class_out_reg <= s1_class_reg;
                pulse_reg     <= pulse;
                period_reg    <= period;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_reg;
    assign is_stable     = stab_out_reg;
    assign current_class = class_out_reg;
    assign report_pulse  = pulse_reg;
    assign run_period_ms = period_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for voltage_class_stability_qualifier_unit.
// Depends on vcsq_pkg and the RTL of the unit; holds its own scoreboard class.
// Covers directed corner words, then random class runs under several limit settings.
`timescale 1ns / 1ps

module tb_top;

    localparam int RING_DEPTH      = 32;
    localparam int HOLD_OFF_CYCLES = 400;
    // Longest honest quiet spell is the hold-off plus a drain; the limit exceeds it.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 4;

    // Class codes that the package does not name.
    localparam vcsq_pkg::class_t CLASS_PROBE_MOUNTED = 3'd1;
    localparam vcsq_pkg::class_t CLASS_DISPENSER     = 3'd2;
    localparam vcsq_pkg::class_t CLASS_DRILL         = 3'd3;
    localparam vcsq_pkg::class_t CLASS_UNKNOWN       = 3'd4;
    localparam vcsq_pkg::class_t CLASS_NO_TOOL       = 3'd5;
    localparam vcsq_pkg::class_t CLASS_SPARE         = 3'd7;

    typedef struct packed {
        logic             accepted;
        logic             is_stable;
        vcsq_pkg::class_t run_class;
        logic             report_pulse;
        vcsq_pkg::time_t  run_period_ms;
    } qual_result_t;

    // Mirrors the qualifier: ring of timestamps, run tracking and the
    // stable/reported flags; queues one expected result per word taken.
    class stability_scoreboard;
        vcsq_pkg::time_t     stamp_ring [RING_DEPTH];
        int unsigned         ring_head;
        int unsigned         ring_fill;
        int unsigned         run_len;
        vcsq_pkg::class_t    run_class;
        bit                  stable;
        bit                  reported;
        vcsq_pkg::cfg_word_t threshold;
        vcsq_pkg::cfg_word_t report_delay;
        qual_result_t        pending_results [$];
        int                  mismatch_count;

        function new();
            ring_head      = 0;
            ring_fill      = 0;
            run_len        = 0;
            run_class      = vcsq_pkg::CLASS_NONE;
            stable         = 1'b0;
            reported       = 1'b0;
            threshold      = vcsq_pkg::THRESHOLD_RESET;
            report_delay   = vcsq_pkg::TRIGGER_DELAY_RESET;
            mismatch_count = 0;
        endfunction

        function void set_limits(vcsq_pkg::cfg_word_t thr, vcsq_pkg::cfg_word_t dly);
            threshold    = thr;
            report_delay = dly;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        function void take_sample(vcsq_pkg::time_t stamp, vcsq_pkg::class_t cls);
            qual_result_t        exp_res;
            int unsigned         slot;
            vcsq_pkg::time_t     span;
            vcsq_pkg::cfg_word_t limit;
            exp_res = '0;
            if (ring_fill > 0 &&
                stamp_ring[(ring_head + RING_DEPTH - 1) % RING_DEPTH] == stamp)
            begin
                exp_res.accepted  = 1'b0;
                exp_res.is_stable = stable;
                exp_res.run_class = run_class;
            end
            else
            begin
                slot             = ring_head;
                stamp_ring[slot] = stamp;
                ring_head        = (ring_head + 1) % RING_DEPTH;
                if (ring_fill < RING_DEPTH)
                    ring_fill++;
                if (cls != run_class)
                begin
                    stable    = 1'b0;
                    reported  = 1'b0;
                    run_class = cls;
                    run_len   = 1;
                end
                else
                    run_len++;
                if (run_len > ring_fill)
                    run_len = ring_fill;
                span = stamp - stamp_ring[(slot + RING_DEPTH - (run_len - 1)) % RING_DEPTH];
                if (!reported)
                begin
                    if (!stable && span >= threshold)
                        stable = 1'b1;
                    limit = (cls == vcsq_pkg::CLASS_PROBE_TRIGGERED) ? report_delay : '0;
                    if (stable && span >= limit)
                    begin
                        reported             = 1'b1;
                        exp_res.report_pulse = 1'b1;
                    end
                end
                exp_res.accepted      = 1'b1;
                exp_res.is_stable     = stable;
                exp_res.run_class     = run_class;
                exp_res.run_period_ms = span;
            end
            pending_results.push_back(exp_res);
        endfunction

        task check_result(qual_result_t got);
            qual_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted)
                report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
            if (got.is_stable !== want.is_stable)
                report($sformatf("is_stable got %0b want %0b", got.is_stable, want.is_stable));
            if (got.run_class !== want.run_class)
                report($sformatf("current_class got %0d want %0d",
                                 got.run_class, want.run_class));
            if (got.report_pulse !== want.report_pulse)
                report($sformatf("report_pulse got %0b want %0b",
                                 got.report_pulse, want.report_pulse));
            if (got.run_period_ms !== want.run_period_ms)
                report($sformatf("run_period_ms got %0h want %0h",
                                 got.run_period_ms, want.run_period_ms));
        endtask
    endclass

    // Clock, reset and every block input start at known values.
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    vcsq_pkg::cfg_idx_t  cfg_index     = vcsq_pkg::REG_STABILITY_THRESHOLD;
    vcsq_pkg::cfg_word_t cfg_wdata     = '0;
    logic                in_valid      = 1'b0;
    vcsq_pkg::time_t     time_ms       = '0;
    vcsq_pkg::class_t    voltage_class = '0;
    logic                out_ready     = 1'b0;

    logic                in_ready;
    logic                out_valid;
    logic                accepted;
    logic                is_stable;
    vcsq_pkg::class_t    current_class;
    logic                report_pulse;
    vcsq_pkg::time_t     run_period_ms;

    stability_scoreboard sb = new();

    int burst_left    = 0;
    bit hold_off_req  = 1'b0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    voltage_class_stability_qualifier_unit #(
        .LOG_DEPTH(RING_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .time_ms       (time_ms),
        .voltage_class (voltage_class),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .is_stable     (is_stable),
        .current_class (current_class),
        .report_pulse  (report_pulse),
        .run_period_ms (run_period_ms)
    );

    // Sample both handshakes at the edge, input first so a prediction is
    // always queued before its result could be checked. Count quiet cycles
    // here too and drop the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_sample(time_ms, voltage_class);
            if (out_valid && out_ready)
                sb.check_result('{accepted, is_stable, current_class,
                                  report_pulse, run_period_ms});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: stall in segments of varying shape, and honor a long
    // hold-off when asked so the unit backs up into its input.
    initial
    begin
        int seg_len;
        int mode;
        int i;
        int k;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(16, 160);
            k       = $urandom_range(2, 5);
            for (i = 0; i < seg_len && !hold_off_req; i++)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 4) == 0);
                    default: out_ready <= ((i % k) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one word and hold it until taken. Words go out in bursts; a
    // burst may start with no gap at all, which keeps back-to-back stretches.
    task automatic send_sample(input vcsq_pkg::time_t stamp, input vcsq_pkg::class_t cls);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        in_valid      <= 1'b1;
        time_ms       <= stamp;
        voltage_class <= cls;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Stop offering and wait for every expected word, then let the pipe settle.
    // Step one edge first so the word taken at this edge is already queued.
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both limits back to back; only called with the unit idle.
    task automatic write_limits(input vcsq_pkg::cfg_word_t thr, input vcsq_pkg::cfg_word_t dly);
        cfg_we    <= 1'b1;
        cfg_index <= vcsq_pkg::REG_STABILITY_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_index <= vcsq_pkg::REG_TRIGGER_DELAY;
        cfg_wdata <= dly;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limits(thr, dly);
    endtask

    // Mostly runs of one class with rising timestamps, steps scaled so the
    // period crosses the limits; sprinkle repeats, wild jumps and lone noise words.
    task automatic run_random(input int n_items, input vcsq_pkg::cfg_word_t thr,
                              input vcsq_pkg::cfg_word_t dly);
        int               counted;
        int               run_len;
        int               i;
        int               pick;
        int unsigned      span_max;
        vcsq_pkg::time_t  step;
        vcsq_pkg::time_t  stamp;
        vcsq_pkg::class_t cls;
        span_max = ((thr > dly) ? thr : dly) / 12 + 2;
        stamp    = $urandom;
        counted  = 0;
        while (counted < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                stamp = $urandom;
                send_sample(stamp, vcsq_pkg::class_t'($urandom_range(0, 7)));
                counted++;
            end
            else
            begin
                cls     = ($urandom_range(0, 9) == 0)
                        ? vcsq_pkg::class_t'($urandom_range(6, 7))
                        : vcsq_pkg::class_t'($urandom_range(0, 5));
                run_len = $urandom_range(1, 48);
                for (i = 0; i < run_len; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        step = '0;
                    else if (pick < 8)
                        step = $urandom;
                    else
                        step = $urandom_range(1, span_max);
                    stamp = stamp + step;
                    send_sample(stamp, cls);
                    if (step != 0)
                        counted++;
                end
            end
        end
    endtask

    task automatic run_phase(input vcsq_pkg::cfg_word_t thr, input vcsq_pkg::cfg_word_t dly,
                             input int n_items, input bit with_hold_off);
        write_limits(thr, dly);
        if (with_hold_off)
            hold_off_req = 1'b1;
        run_random(n_items, thr, dly);
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset limits (200 / 200).
        send_sample(32'd5, vcsq_pkg::CLASS_NONE);            // first word matches reset class
        send_sample(32'd5, CLASS_DRILL);                     // repeated stamp: dropped
        send_sample(32'd0, vcsq_pkg::CLASS_PROBE_TRIGGERED); // class change, period 0
        send_sample(32'd100, vcsq_pkg::CLASS_PROBE_TRIGGERED);
        send_sample(32'd250, vcsq_pkg::CLASS_PROBE_TRIGGERED); // stable and reported
        send_sample(32'd300, vcsq_pkg::CLASS_PROBE_TRIGGERED); // already reported
        send_sample(32'd301, CLASS_PROBE_MOUNTED);
        send_sample(32'd450, CLASS_PROBE_MOUNTED);
        send_sample(32'd600, CLASS_PROBE_MOUNTED);   // no report delay off probe class
        send_sample(32'd600, CLASS_PROBE_MOUNTED);
        send_sample(32'hFFFF_FFF0, CLASS_DISPENSER);
        send_sample(32'h0000_00F0, CLASS_DISPENSER); // period wraps through zero
        send_sample(32'hFFFF_FFFF, CLASS_DRILL);
        send_sample(32'hFFFF_FFFF, CLASS_UNKNOWN);
        send_sample(32'h7FFF_FFFF, CLASS_UNKNOWN);
        send_sample(32'h8000_0000, CLASS_NO_TOOL);
        send_sample(32'd1, vcsq_pkg::CLASS_NONE);
        send_sample(32'd2, CLASS_SPARE);
        send_sample(32'd500, CLASS_SPARE);
        send_sample(32'd501, vcsq_pkg::CLASS_PROBE_TRIGGERED);
        send_sample(32'd720, vcsq_pkg::CLASS_PROBE_TRIGGERED);
        drain_results();

        // Random phases, extremes first; the second one also holds off the
        // result side long enough to back the unit up.
        run_phase(16'd0, 16'd0, 170, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 170, 1'b1);
        run_phase(16'd0, 16'hFFFF, 170, 1'b0);
        run_phase(16'hFFFF, 16'd0, 170, 1'b0);
        run_phase(vcsq_pkg::THRESHOLD_RESET, vcsq_pkg::TRIGGER_DELAY_RESET, 170, 1'b0);
        run_phase(vcsq_pkg::cfg_word_t'($urandom_range(0, 400)),
                  vcsq_pkg::cfg_word_t'($urandom_range(0, 400)), 170, 1'b0);
        run_phase(vcsq_pkg::cfg_word_t'($urandom_range(0, 65535)),
                  vcsq_pkg::cfg_word_t'($urandom_range(0, 65535)), 170, 1'b0);

        drain_results();
        if (sb.pending_results.size() != 0)
            sb.report("expected words left over at end of run");
        if (sb.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
